// ===== design/chba_pkg.sv =====
// Shared constants, payload types and a helper function of the context handle allocator.
`timescale 1ns / 1ps

package chba_pkg;

  localparam int unsigned CONTEXTS          = 256;
  localparam int unsigned RESERVED_CONTEXTS = 1;
  localparam int unsigned HANDLE_W          = 15;
  localparam int unsigned HIGH_W            = 16;
  localparam int unsigned WORD_W            = 32;
  localparam int unsigned BIT_W             = $clog2(WORD_W);
  localparam int unsigned WORDS             = CONTEXTS / WORD_W;
  localparam int unsigned WIDX_W            = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned HW_W              = $clog2(CONTEXTS + 1);

  // Reset contents of map word zero: the reserved handles are in use.
  localparam logic [WORD_W-1:0] RSV_MASK =
    WORD_W'((64'd1 << RESERVED_CONTEXTS) - 64'd1);

  localparam logic [HANDLE_W-1:0] KERNEL_HANDLE = '0;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  typedef struct packed {
    logic                operation;
    logic [HANDLE_W-1:0] handle;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [HANDLE_W-1:0] granted_handle;
    logic [HIGH_W-1:0]   high_water;
  } rsp_t;

  // Position of the lowest clear bit of a map word.
  function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_W-1:0] word);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!word[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

// ===== design/chba_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
`timescale 1ns / 1ps

module chba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/context_handle_bitmap_allocator.sv =====
// Top level of the context handle allocator: bitmap in RAM, word scan and result register.
`timescale 1ns / 1ps

// The block hands out context handles from an in-use bitmap and takes them back.
// A request arrives on the input channel (in_valid_i, in_stall_o, in_i) and
// carries an operation and, for a free, the handle. Every request gives exactly
// one result on the output channel (out_valid_o, out_stall_i, out_o) with a
// status, the granted handle and the high-water mark after the request.
// The bitmap lives in a RAM of 32-bit words. An allocate reads the words in
// order, one per cycle, and takes the lowest clear bit of the first word that
// has one, or reports a full map when none has. A free is a read, a modify and
// a write back; a bad handle or the kernel handle goes straight to the result.
// The block works on one request at a time and raises in_stall_o until that
// request's result has moved into the output register. The output register
// holds the result while the receiver stalls, and the next request is
// accepted meanwhile; its result waits in the block until the register frees.
// Reset clears all handles except the reserved ones and sets the high-water
// mark to the number of reserved handles. The RAM needs no clearing pass: a
// per-word valid flag makes a never-written word read as its reset contents.
module context_handle_bitmap_allocator
  import chba_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_FREE = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [WIDX_W-1:0]   idx_q, idx_d;
  logic [BIT_W-1:0]    bit_q, bit_d;
  logic [WORDS-1:0]    wvalid_q, wvalid_d;
  logic [HW_W-1:0]     hw_q, hw_d;
  rsp_t                res_q, res_d;
  rsp_t                out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic                ram_re;
  logic [WIDX_W-1:0]   ram_raddr;
  logic                ram_we;
  logic [WORD_W-1:0]   ram_wdata;
  logic [WORD_W-1:0]   ram_rdata;

  logic [WORD_W-1:0]   word_eff;
  logic [BIT_W-1:0]    zero_bit;
  logic [HW_W-1:0]     cand;
  logic                in_range;
  logic [WIDX_W-1:0]   h_word;
  logic [BIT_W-1:0]    h_bit;

  chba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // A word that was never written since reset reads as its reset contents.
  assign word_eff = wvalid_q[idx_q] ? ram_rdata :
                    ((idx_q == '0) ? RSV_MASK : '0);
  assign zero_bit = first_zero(word_eff);
  assign cand     = HW_W'({idx_q, zero_bit}) + HW_W'(1);

  assign in_range = {1'b0, in_i.handle} < (HANDLE_W + 1)'(CONTEXTS);
  assign h_word   = in_i.handle[BIT_W +: WIDX_W];
  assign h_bit    = in_i.handle[BIT_W-1:0];

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    bit_d       = bit_q;
    wvalid_d    = wvalid_q;
    hw_d        = hw_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_re      = 1'b0;
    ram_raddr   = idx_q;
    ram_we      = 1'b0;
    ram_wdata   = word_eff;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_d.status         = ST_OK;
          res_d.granted_handle = '0;
          res_d.high_water     = HIGH_W'(hw_q);
          if (in_i.operation == OP_ALLOC) begin
            idx_d     = '0;
            ram_re    = 1'b1;
            ram_raddr = '0;
            state_d   = S_SCAN;
          end else if (!in_range) begin
            res_d.status = ST_BAD;
            state_d      = S_RESP;
          end else if (in_i.handle == KERNEL_HANDLE) begin
            // The kernel context is never released.
            state_d = S_RESP;
          end else begin
            idx_d     = h_word;
            bit_d     = h_bit;
            ram_re    = 1'b1;
            ram_raddr = h_word;
            state_d   = S_FREE;
          end
        end
      end
      S_SCAN: begin
        if (word_eff != '1) begin
          ram_we           = 1'b1;
          ram_wdata        = word_eff | (WORD_W'(1) << zero_bit);
          wvalid_d[idx_q]  = 1'b1;
          if (cand > hw_q) begin
            hw_d = cand;
          end
          res_d.status         = ST_OK;
          res_d.granted_handle = HANDLE_W'({idx_q, zero_bit});
          res_d.high_water     = HIGH_W'(hw_d);
          state_d              = S_RESP;
        end else if (idx_q == WIDX_W'(WORDS - 1)) begin
          res_d.status = ST_FULL;
          state_d      = S_RESP;
        end else begin
          idx_d     = idx_q + WIDX_W'(1);
          ram_re    = 1'b1;
          ram_raddr = idx_q + WIDX_W'(1);
        end
      end
      S_FREE: begin
        ram_we          = 1'b1;
        ram_wdata       = word_eff & ~(WORD_W'(1) << bit_q);
        wvalid_d[idx_q] = 1'b1;
        state_d         = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wvalid_q    <= '0;
      hw_q        <= HW_W'(RESERVED_CONTEXTS);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wvalid_q    <= wvalid_d;
      hw_q        <= hw_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    bit_q <= bit_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  // A failed request reports handle zero, as a free does.
  a_fail_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.status != ST_OK) |-> (out_o.granted_handle == '0))
    else $error("failed request reports a granted handle");

  // A granted handle always lies below the reported high-water mark.
  a_grant_below_hw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.status == ST_OK) |->
    ({1'b0, out_o.granted_handle} < out_o.high_water))
    else $error("granted handle not below high-water mark");

  // The high-water mark never falls.
  a_hw_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (hw_q >= $past(hw_q)))
    else $error("high-water mark decreased");

  // The map is only written while a request works on a word read before.
  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_SCAN || state_q == S_FREE))
    else $error("map written outside a scan or free");

endmodule

// ===== tb/context_handle_bitmap_allocator_tb.sv =====
// Self-checking testbench of the context handle allocator: directed, fill and random traffic.
`timescale 1ns / 1ps

// The bench drives allocate and free requests into the block and checks every
// response against its own bitmap and high-water mark. Each request is
// resolved at the clock edge where its transfer happens, and the response it
// should cause goes to the back of a queue. The response checker compares
// every output transfer with the head of that queue, field by field.
//
// Requests change at the falling edge and handshakes are sampled at the
// rising edge, so the block's registered outputs are always read with their
// values from before the edge.
module context_handle_bitmap_allocator_tb
  import chba_pkg::*;
;

  localparam int          HALF_PERIOD     = 6;
  localparam int          RESET_CYCLES    = 8;
  localparam int          HOLD_OFF_CYCLES = 200;
  // An allocate reads at most CONTEXTS/32 map words.
  localparam int          DRAIN_CYCLES    = 2 * (CONTEXTS / WORD_W + 2) + 8;
  localparam int          CYCLE_LIMIT     = 400000;
  localparam int unsigned HANDLE_MAX      = (1 << HANDLE_W) - 1;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  req_t in_i;
  logic out_valid_o;
  logic out_stall_i;
  rsp_t out_o;

  // Bench copy of the allocator state, updated at each input transfer.
  bit [CONTEXTS-1:0] handle_busy;
  int unsigned       peak_mark;

  // Responses that the accepted requests should still cause, oldest first.
  rsp_t awaited_rsp[$];

  int error_count = 0;
  int cycle_count = 0;

  // Idling controls shared by the test tasks and the two channel processes.
  bit tx_gaps_en   = 1'b1;
  bit rx_stalls_en = 1'b1;
  bit hold_off_req = 1'b0;

  context_handle_bitmap_allocator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  initial begin
    clk_i = 1'b0;
  end

  always #HALF_PERIOD clk_i = ~clk_i;

  // A run that hangs on a handshake ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("context_handle_bitmap_allocator regression: fail");
      $finish;
    end
  end

  // Back-to-back half the time, often a few cycles, now and then a long pause.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(1, 3);
    end else if (roll < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Works out the response to one request and moves the bench state along.
  // An allocate takes the lowest clear bit; a free clears any in-range bit
  // except the kernel handle, and the high-water mark never goes down.
  function automatic rsp_t resolve_request(input req_t req);
    rsp_t rsp;
    rsp = '0;
    rsp.status = ST_OK;
    if (req.operation == OP_ALLOC) begin
      rsp.status = ST_FULL;
      for (int i = 0; i < CONTEXTS; i++) begin
        if (!handle_busy[i]) begin
          handle_busy[i] = 1'b1;
          if (i + 1 > peak_mark) begin
            peak_mark = i + 1;
          end
          rsp.granted_handle = HANDLE_W'(i);
          rsp.status         = ST_OK;
          break;
        end
      end
    end else if (req.handle >= CONTEXTS) begin
      rsp.status = ST_BAD;
    end else if (req.handle != KERNEL_HANDLE) begin
      handle_busy[req.handle[WIDX_W+BIT_W-1:0]] = 1'b0;
    end
    rsp.high_water = HIGH_W'(peak_mark);
    return rsp;
  endfunction

  // A handle in use right now, if any, found by a wrapping scan from a random
  // start. The kernel handle is skipped since freeing it changes nothing.
  function automatic logic [HANDLE_W-1:0] pick_busy_handle();
    int start;
    int idx;
    start = $urandom_range(1, CONTEXTS - 1);
    for (int n = 0; n < CONTEXTS - 1; n++) begin
      idx = 1 + (start - 1 + n) % (CONTEXTS - 1);
      if (handle_busy[idx]) begin
        return HANDLE_W'(idx);
      end
    end
    return HANDLE_W'(start);
  endfunction

  function automatic logic [HANDLE_W-1:0] any_handle_bits();
    return HANDLE_W'($urandom_range(0, HANDLE_MAX));
  endfunction

  // Offers one request and waits for its transfer. Valid drops at the falling
  // edge right after the transfer, so an offered payload never changes while
  // the block stalls it.
  task automatic send_request(input logic op, input logic [HANDLE_W-1:0] handle);
    req_t req;
    int   idle;
    req.operation = op;
    req.handle    = handle;
    idle = tx_gaps_en ? pick_gap() : 0;
    repeat (idle) @(negedge clk_i);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_i       <= req;
    do @(posedge clk_i); while (in_stall_o);
    awaited_rsp.push_back(resolve_request(req));
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // The receiver: random stall bursts while enabled, and one long hold-off
  // on request, counted here so that the sender keeps pushing meanwhile.
  initial begin : response_sink
    int stall_left;
    stall_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left  = stall_left - 1;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i  <= 1'b1;
        stall_left   = HOLD_OFF_CYCLES - 1;
      end else if (rx_stalls_en && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        stall_left  = pick_gap();
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Every output transfer is matched against the oldest awaited response.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_rsp.size() == 0) begin
        $error("response with nothing awaited: status %0d handle %0d high_water %0d",
               out_o.status, out_o.granted_handle, out_o.high_water);
        error_count++;
      end else begin
        want = awaited_rsp.pop_front();
        if (out_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_o.status);
          error_count++;
        end
        if (out_o.granted_handle !== want.granted_handle) begin
          $error("granted_handle: expected %0d, got %0d",
                 want.granted_handle, out_o.granted_handle);
          error_count++;
        end
        if (out_o.high_water !== want.high_water) begin
          $error("high_water: expected %0d, got %0d", want.high_water, out_o.high_water);
          error_count++;
        end
      end
    end
  end

  // Each operation and each corner of the handle field: the kernel handle,
  // a handle that is already free, the last handle in the table, the first
  // and the last handle beyond it, and a free below the high-water mark that
  // must leave the mark where it is. Allocates carry junk in the handle field.
  task automatic test_basic_ops();
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, HANDLE_W'(HANDLE_MAX));
    send_request(OP_ALLOC, HANDLE_W'(15'h5555));
    send_request(OP_FREE,  KERNEL_HANDLE);
    send_request(OP_FREE,  HANDLE_W'(2));
    send_request(OP_FREE,  HANDLE_W'(2));
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE,  HANDLE_W'(CONTEXTS - 1));
    send_request(OP_FREE,  HANDLE_W'(CONTEXTS));
    send_request(OP_FREE,  HANDLE_W'(HANDLE_MAX));
    send_request(OP_FREE,  HANDLE_W'(15'h5555));
    send_request(OP_FREE,  HANDLE_W'(15'h2AAA));
    send_request(OP_FREE,  HANDLE_W'(1));
    send_request(OP_FREE,  HANDLE_W'(3));
    send_request(OP_ALLOC, HANDLE_W'(15'h2AAA));
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
  endtask

  // Allocates every remaining handle, then runs into the full map, frees a
  // few and takes them back. The first burst goes out back-to-back while the
  // receiver holds off for a long stretch, so the block has to stall input.
  task automatic test_fill_until_full();
    int free_total;
    free_total = 0;
    for (int i = 0; i < CONTEXTS; i++) begin
      if (!handle_busy[i]) begin
        free_total++;
      end
    end
    tx_gaps_en   = 1'b0;
    rx_stalls_en = 1'b0;
    hold_off_req = 1'b1;
    for (int n = 0; n < free_total; n++) begin
      if (n == 24) begin
        tx_gaps_en   = 1'b1;
        rx_stalls_en = 1'b1;
      end
      send_request(OP_ALLOC, any_handle_bits());
    end
    repeat (3) send_request(OP_ALLOC, any_handle_bits());
    repeat (5) send_request(OP_FREE, pick_busy_handle());
    repeat (6) send_request(OP_ALLOC, any_handle_bits());
  endtask

  // Chunks of mixed traffic, each with its own allocate share so that the
  // map drains and refills. Most frees hit a handle in use; the rest free an
  // arbitrary in-range handle, the kernel handle or one beyond the table.
  // Every fourth chunk runs without any idling on either side.
  task automatic test_random_traffic();
    int alloc_pct;
    int roll;
    for (int chunk = 0; chunk < 14; chunk++) begin
      case ($urandom_range(0, 3))
        0: begin
          alloc_pct = 25;
        end
        1: begin
          alloc_pct = 50;
        end
        2: begin
          alloc_pct = 70;
        end
        default: begin
          alloc_pct = 90;
        end
      endcase
      tx_gaps_en   = (chunk % 4 != 3);
      rx_stalls_en = (chunk % 4 != 3);
      for (int n = 0; n < 40; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct) begin
          send_request(OP_ALLOC, any_handle_bits());
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 70) begin
            send_request(OP_FREE, pick_busy_handle());
          end else if (roll < 80) begin
            send_request(OP_FREE, HANDLE_W'($urandom_range(0, CONTEXTS - 1)));
          end else if (roll < 85) begin
            send_request(OP_FREE, KERNEL_HANDLE);
          end else begin
            send_request(OP_FREE, HANDLE_W'($urandom_range(CONTEXTS, HANDLE_MAX)));
          end
        end
      end
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_i       = '0;

    // State after reset: only the reserved handles are taken.
    handle_busy = '0;
    for (int i = 0; i < RESERVED_CONTEXTS; i++) begin
      handle_busy[i] = 1'b1;
    end
    peak_mark = RESERVED_CONTEXTS;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_basic_ops();
    test_fill_until_full();
    test_random_traffic();

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Let the last responses come out, then leave room for a stray one.
    while (awaited_rsp.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("context_handle_bitmap_allocator regression: pass");
    end else begin
      $display("context_handle_bitmap_allocator regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/chba_pkg.sv
design/chba_ram.sv
design/context_handle_bitmap_allocator.sv
tb/context_handle_bitmap_allocator_tb.sv
